// ===== sv/mbrf_pkg.sv =====
// Shared types, constants and the CRC byte update for the Modbus RTU request framer.
// No dependencies.
package mbrf_pkg;

  localparam int BODY_MAX = 9;   // longest frame body (write), CRC excluded
  localparam int IDX_W    = 4;   // byte index within a frame, 0..10

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_READ  = 1'b1;

  localparam logic [7:0] FN_WRITE_MULTI   = 8'h10;
  localparam logic [7:0] FN_READ_HOLDING  = 8'h03;
  localparam logic [7:0] WRITE_BYTE_COUNT = 8'h02;
  localparam logic [7:0] WRITE_QTY_LO     = 8'h01;
  localparam logic [7:0] WRITE_QTY_HI     = 8'h00;

  localparam logic [IDX_W-1:0] BODY_LEN_WRITE = 4'd9;
  localparam logic [IDX_W-1:0] BODY_LEN_READ  = 4'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One queued request: frame body bytes in wire order plus their count.
  typedef struct packed {
    logic [IDX_W-1:0]             body_len;
    logic [BODY_MAX-1:0][7:0]     body;
  } req_desc_t;

  // CRC-16/Modbus, one byte, reflected (LSB first).
  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/mbrf_front.sv =====
// Front end: classifies a request and lays out its frame body.
// Depends on mbrf_pkg.
module mbrf_front import mbrf_pkg::*; (
  input  logic        cmd,
  input  logic [7:0]  slave_addr,
  input  logic [15:0] reg_addr,
  input  logic [15:0] data_value,
  output req_desc_t   desc
);

  always_comb begin
    desc      = '0;
    desc.body[0] = slave_addr;
    desc.body[2] = reg_addr[15:8];
    desc.body[3] = reg_addr[7:0];
    unique case (cmd)
      CMD_READ: begin
        desc.body_len = BODY_LEN_READ;
        desc.body[1]  = FN_READ_HOLDING;
        desc.body[4]  = data_value[15:8];
        desc.body[5]  = data_value[7:0];
      end
      default: begin
        // single register write: quantity 1, byte count 2
        desc.body_len = BODY_LEN_WRITE;
        desc.body[1]  = FN_WRITE_MULTI;
        desc.body[4]  = WRITE_QTY_HI;
        desc.body[5]  = WRITE_QTY_LO;
        desc.body[6]  = WRITE_BYTE_COUNT;
        desc.body[7]  = data_value[15:8];
        desc.body[8]  = data_value[7:0];
      end
    endcase
  end

endmodule

// ===== sv/mbrf_queue.sv =====
// Small FIFO of request descriptors between front and back end.
// Depends on mbrf_pkg.
module mbrf_queue import mbrf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  req_desc_t push_desc,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output req_desc_t head_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  req_desc_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full       = (count_r == DEPTH_C);
  assign head_valid = (count_r != '0);
  assign head_desc  = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== sv/mbrf_back.sv =====
// Back end: serializes the queued frame body, appends the CRC, drives the output register.
// Depends on mbrf_pkg.
module mbrf_back import mbrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  req_desc_t  head_desc,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_last
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_frame_byte_r, out_frame_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic       fire;
  logic       in_body;
  logic       is_last;
  logic [7:0] cur_byte;

  assign fire    = head_valid && (!out_valid_r || !out_stall);
  assign in_body = (idx_r < head_desc.body_len);
  assign is_last = (idx_r == head_desc.body_len + 1'b1);
  assign pop     = fire && is_last;

  always_comb begin
    if (in_body) begin
      cur_byte = head_desc.body[idx_r];
    end else if (idx_r == head_desc.body_len) begin
      cur_byte = crc_r[7:0];
    end else begin
      cur_byte = crc_r[15:8];
    end
  end

  always_comb begin
    idx_nxt            = idx_r;
    crc_nxt            = crc_r;
    out_frame_byte_nxt = out_frame_byte_r;
    out_last_nxt       = out_last_r;
    out_valid_nxt      = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt      = 1'b1;
      out_frame_byte_nxt = cur_byte;
      out_last_nxt       = is_last;
      if (is_last) begin
        idx_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (in_body) begin
          crc_nxt = crc_feed(crc_r, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_frame_byte_r <= out_frame_byte_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_last       = out_last_r;

endmodule

// ===== sv/modbus_rtu_request_framer.sv =====
// Top level of the Modbus RTU request framer: front end, request queue, back end.
// Depends on mbrf_pkg, mbrf_front, mbrf_queue, mbrf_back.
//
// Usage:
//   Input channel (in_*): one request per accepted handshake. in_cmd = 0 builds
//   a function 0x10 single-register write (11 bytes), in_cmd = 1 a function 0x03
//   read (8 bytes). Output channel (out_*): one frame byte per handshake in wire
//   order, CRC-16/Modbus low byte then high byte, out_last high on the final byte.
//   Both channels: a transfer happens when valid is high and stall is low.
// The first byte of a request is registered in the queue and then in the output
//   register before out_valid shows it (when the back end is idle).
// Throughput: one byte per cycle while out_stall is low; the back end's byte
//   serializer sets that rate. Frames go out back to back with no gap when the
//   next request is already queued.
// The queue holds QUEUE_DEPTH requests, so the front keeps taking requests
//   while a frame is still being sent; in_stall rises only when it is full.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// When out_stall is high the current byte holds, the serializer waits, and
//   requests keep filling the queue until it is full.
module modbus_rtu_request_framer import mbrf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_slave_addr,
  input  logic [15:0] in_reg_addr,
  input  logic [15:0] in_data_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last
);

  req_desc_t front_desc;
  req_desc_t head_desc;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      head_valid;

  // request accepted this cycle
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  mbrf_front u_front (
    .cmd        (in_cmd),
    .slave_addr (in_slave_addr),
    .reg_addr   (in_reg_addr),
    .data_value (in_data_value),
    .desc       (front_desc)
  );

  mbrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (front_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  // serializer pops the queue head together with the last byte of its frame
  mbrf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_desc      (head_desc),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last)
  );

endmodule
